// ===== rtl/sbusfd_pkg.sv =====
package sbusfd_pkg;

    localparam int unsigned NUM_CHANNELS_DEF = 16;
    localparam int unsigned CHANNEL_BITS     = 11;
    localparam int unsigned DATA_BYTES       = 22;
    localparam int unsigned POS_BITS         = 5;

    localparam logic [7:0] SYNC_BYTE     = 8'h0F;
    localparam logic [7:0] GAP_LIMIT_RST = 8'd2;
    localparam logic [7:0] GAP_MAX       = 8'hFF;

    // byte positions after the sync byte
    localparam logic [POS_BITS-1:0] FLAGS_POS = POS_BITS'(DATA_BYTES);

    localparam logic [7:0] END_BYTE_0 = 8'h00;
    localparam logic [7:0] END_BYTE_1 = 8'h04;
    localparam logic [7:0] END_BYTE_2 = 8'h14;
    localparam logic [7:0] END_BYTE_3 = 8'h24;
    localparam logic [7:0] END_BYTE_4 = 8'h34;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic {
        RX_SYNC,
        RX_DATA
    } t_rx_state;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [3:0]              channel_index;
        logic [CHANNEL_BITS-1:0] channel_value;
        logic [7:0]              frame_flags;
        logic                    last_channel;
    } t_out_word;

    function automatic logic end_byte_ok(input logic [7:0] b);
        return (b == END_BYTE_0) || (b == END_BYTE_1) || (b == END_BYTE_2) ||
               (b == END_BYTE_3) || (b == END_BYTE_4);
    endfunction

endpackage

// ===== rtl/sbusfd_front.sv =====
module sbusfd_front #(
    parameter int unsigned FRAME_W = sbusfd_pkg::NUM_CHANNELS_DEF * sbusfd_pkg::CHANNEL_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_accept,
    input  sbusfd_pkg::t_in_word i_word,
    output logic                 o_push,
    output logic [FRAME_W-1:0]   o_frame,
    output logic [7:0]           o_flags
);

    localparam int unsigned STORE_W = sbusfd_pkg::DATA_BYTES * 8;

    sbusfd_pkg::t_rx_state r_state, n_state;
    logic [sbusfd_pkg::POS_BITS-1:0] r_pos, n_pos;
    logic [7:0] r_gap, n_gap;
    logic [7:0] r_gap_limit;
    logic [7:0] r_flags;
    logic [7:0] r_store [sbusfd_pkg::DATA_BYTES];
    logic [STORE_W-1:0] w_store_flat;

    logic w_byte, w_timeout, w_receiving, w_in_data, w_at_flags, w_at_end;
    logic [sbusfd_pkg::POS_BITS-1:0] w_pos_eff;

    assign w_byte      = i_accept && (i_word.mode == sbusfd_pkg::MODE_BYTE);
    assign w_timeout   = r_gap > r_gap_limit;
    assign w_receiving = (r_state == sbusfd_pkg::RX_DATA) && !w_timeout;
    assign w_pos_eff   = w_timeout ? '0 : r_pos;
    assign w_in_data   = w_byte && w_receiving &&
                         (w_pos_eff < sbusfd_pkg::FLAGS_POS);
    assign w_at_flags  = w_byte && w_receiving &&
                         (w_pos_eff == sbusfd_pkg::FLAGS_POS);
    assign w_at_end    = w_byte && w_receiving &&
                         (w_pos_eff > sbusfd_pkg::FLAGS_POS);

    // next state
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        if (w_byte) begin
            unique case (w_receiving)
                1'b0: begin
                    n_pos = '0;
                    if (i_word.rx_byte == sbusfd_pkg::SYNC_BYTE) begin
                        n_state = sbusfd_pkg::RX_DATA;
                    end else begin
                        n_state = sbusfd_pkg::RX_SYNC;
                    end
                end
                1'b1: begin
                    if (w_at_end) begin
                        n_state = sbusfd_pkg::RX_SYNC;
                        n_pos   = '0;
                    end else begin
                        n_state = sbusfd_pkg::RX_DATA;
                        n_pos   = w_pos_eff + 1'b1;
                    end
                end
                default: begin
                    n_state = sbusfd_pkg::RX_SYNC;
                end
            endcase
        end
    end

    // gap counter, saturating
    always_comb begin
        n_gap = r_gap;
        if (i_accept) begin
            if (i_word.mode == sbusfd_pkg::MODE_TICK) begin
                if (r_gap != sbusfd_pkg::GAP_MAX) begin
                    n_gap = r_gap + 1'b1;
                end
            end else begin
                n_gap = '0;
            end
        end
    end

    // outputs
    always_comb begin
        for (int i = 0; i < int'(sbusfd_pkg::DATA_BYTES); i++) begin
            w_store_flat[i*8 +: 8] = r_store[i];
        end
        o_push  = w_at_end && sbusfd_pkg::end_byte_ok(i_word.rx_byte);
        o_frame = w_store_flat[FRAME_W-1:0];
        o_flags = r_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbusfd_pkg::RX_SYNC;
            r_pos       <= '0;
            r_gap       <= '0;
            r_gap_limit <= sbusfd_pkg::GAP_LIMIT_RST;
            r_flags     <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_gap   <= n_gap;
            if (i_cfg_we) begin
                r_gap_limit <= i_cfg_data;
            end
            if (w_at_flags) begin
                r_flags <= i_word.rx_byte;
            end
        end
    end

    // data bytes, written in arrival order
    always_ff @(posedge i_clk) begin
        if (w_in_data) begin
            r_store[w_pos_eff] <= i_word.rx_byte;
        end
    end

endmodule

// ===== rtl/sbusfd_queue.sv =====
module sbusfd_queue #(
    parameter int unsigned FRAME_W = sbusfd_pkg::NUM_CHANNELS_DEF * sbusfd_pkg::CHANNEL_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [FRAME_W-1:0] i_frame,
    input  logic [7:0]         i_flags,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output logic [FRAME_W-1:0] o_frame,
    output logic [7:0]         o_flags
);

    // two frame slots
    logic [FRAME_W-1:0] r_frame [2];
    logic [7:0]         r_flags [2];
    logic               r_wr_ptr, r_rd_ptr;
    logic [1:0]         r_count;
    logic               w_do_push, w_do_pop;

    assign o_full    = r_count[1];
    assign o_valid   = r_count != 2'd0;
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;
    assign o_frame   = r_frame[r_rd_ptr];
    assign o_flags   = r_flags[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_frame[r_wr_ptr] <= i_frame;
            r_flags[r_wr_ptr] <= i_flags;
        end
    end

endmodule

// ===== rtl/sbusfd_back.sv =====
module sbusfd_back #(
    parameter int unsigned NUM_CHANNELS = sbusfd_pkg::NUM_CHANNELS_DEF,
    parameter int unsigned FRAME_W      = NUM_CHANNELS * sbusfd_pkg::CHANNEL_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [FRAME_W-1:0]    i_frame,
    input  logic [7:0]            i_flags,
    output logic                  o_take,
    input  logic                  i_pop,
    output logic                  o_empty,
    output sbusfd_pkg::t_out_word o_word
);

    localparam logic [3:0] LAST_CH = 4'(NUM_CHANNELS - 1);

    logic                  r_busy;
    logic [FRAME_W-1:0]    r_shift;
    logic [7:0]            r_flags;
    logic [3:0]            r_cnt;
    logic                  r_out_valid;
    sbusfd_pkg::t_out_word r_out;
    logic                  w_adv, w_emit, w_last;

    assign w_adv   = !r_out_valid || i_pop;
    assign w_emit  = w_adv && r_busy;
    assign w_last  = r_cnt == LAST_CH;
    assign o_take  = !r_busy && i_valid;
    assign o_empty = !r_out_valid;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_emit) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (w_adv) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // channel data: shift right one channel per word sent
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_shift <= i_frame;
            r_flags <= i_flags;
        end else if (w_emit) begin
            r_shift <= r_shift >> sbusfd_pkg::CHANNEL_BITS;
        end
        if (w_emit) begin
            r_out.channel_index <= r_cnt;
            r_out.channel_value <= r_shift[sbusfd_pkg::CHANNEL_BITS-1:0];
            r_out.frame_flags   <= r_flags;
            r_out.last_channel  <= w_last;
        end
    end

endmodule

// ===== rtl/sbus_frame_decoder.sv =====
// S.BUS frame decoder: bytes and ms ticks in, one word per channel out.
// The end byte of a good frame is written to the frame queue, the back end takes
// the frame, then channel 0 appears on the registered outputs, then one channel
// word per cycle while pop keeps up. Throughput: one input word per cycle while full is low.
// Reset (i_rst_n low, synchronous): sync search, gap limit 2, queues empty.
module sbus_frame_decoder #(
    parameter int unsigned NUM_CHANNELS = sbusfd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input word queue side
    input  logic                  push,
    output logic                  full,
    input  sbusfd_pkg::t_in_word  i_in,
    // result word queue side
    output logic                  empty,
    input  logic                  pop,
    output sbusfd_pkg::t_out_word o_out,
    // gap limit register
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_data
);

    // only the bits that carry the configured channels are kept per frame
    localparam int unsigned FRAME_W = NUM_CHANNELS * sbusfd_pkg::CHANNEL_BITS;

    logic               w_accept;
    logic               w_fr_push;
    logic [FRAME_W-1:0] w_fr_data;
    logic [7:0]         w_fr_flags;
    logic               w_q_full;
    logic               w_q_valid;
    logic [FRAME_W-1:0] w_q_frame;
    logic [7:0]         w_q_flags;
    logic               w_q_pop;

    // Input stalls only while both frame slots are taken; that keeps a good
    // end byte from ever arriving with nowhere to put its frame.
    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    // Front: gap counter, sync search, byte collection, end byte check.
    sbusfd_front #(
        .FRAME_W (FRAME_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_word     (i_in),
        .o_push     (w_fr_push),
        .o_frame    (w_fr_data),
        .o_flags    (w_fr_flags)
    );

    // Two-deep frame queue decouples byte intake from channel output.
    sbusfd_queue #(
        .FRAME_W (FRAME_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fr_push),
        .i_frame (w_fr_data),
        .i_flags (w_fr_flags),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_frame (w_q_frame),
        .o_flags (w_q_flags)
    );

    // Back: unpacks 11-bit channels LSB first into a registered output word.
    sbusfd_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .FRAME_W      (FRAME_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_frame (w_q_frame),
        .i_flags (w_q_flags),
        .o_take  (w_q_pop),
        .i_pop   (pop),
        .o_empty (empty),
        .o_word  (o_out)
    );

endmodule
